@@ design/tilt_rotation_dimmer_assert.svh @@
// Assertion macros for the tilt and rotation dimmer.
`ifndef TILT_ROTATION_DIMMER_ASSERT_SVH
`define TILT_ROTATION_DIMMER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property while out of reset.
`define TRD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tilt_rotation_dimmer assertion failed");

// Check a property on every edge, reset included.
`define TRD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tilt_rotation_dimmer reset assertion failed");

`else

`define TRD_ASSERT(lbl, prop)
`define TRD_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ design/trd_pkg.sv @@
// Package for the tilt and rotation dimmer: register map, constants, gamma table.
package trd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned PosW     = 9;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RISE_START    = 3'd0,
    REG_UPRIGHT_LOW   = 3'd1,
    REG_UPRIGHT_HIGH  = 3'd2,
    REG_RELEASE       = 3'd3,
    REG_LIGHT_FLOOR   = 3'd4,
    REG_LEVEL_SHIFT   = 3'd5,
    REG_RATE_DEADBAND = 3'd6,
    REG_SHAKE_LIMIT   = 3'd7
  } cfg_idx_t;

  localparam logic [7:0]  RISE_START_RST    = 8'd15;
  localparam logic [7:0]  UPRIGHT_LOW_RST   = 8'd117;
  localparam logic [7:0]  UPRIGHT_HIGH_RST  = 8'd150;
  localparam logic [7:0]  RELEASE_RST       = 8'd100;
  localparam logic [7:0]  LIGHT_FLOOR_RST   = 8'd10;
  localparam logic [2:0]  LEVEL_SHIFT_RST   = 3'd0;
  localparam logic [14:0] RATE_DEADBAND_RST = 15'd200;
  localparam logic [14:0] SHAKE_LIMIT_RST   = 15'd180;

  localparam int unsigned RateShift = 7;
  localparam logic signed [10:0] POS_MAX = 11'sd255;
  localparam logic signed [10:0] POS_MIN = -11'sd255;
  localparam logic [7:0] WHEEL_THIRD    = 8'd85;
  localparam logic [7:0] WHEEL_TWOTHIRD = 8'd170;

  localparam logic [7:0] GAMMA_ROM [256] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd2,
      8'd2,   8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd3,   8'd3,
      8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,   8'd5,   8'd6,
      8'd6,   8'd6,   8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd9,
      8'd9,   8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd12,  8'd12,
      8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,
      8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd21,
      8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,  8'd25,  8'd26,
      8'd26,  8'd27,  8'd28,  8'd28,  8'd29,  8'd30,  8'd30,  8'd31,
      8'd32,  8'd32,  8'd33,  8'd34,  8'd35,  8'd35,  8'd36,  8'd37,
      8'd38,  8'd38,  8'd39,  8'd40,  8'd41,  8'd41,  8'd42,  8'd43,
      8'd44,  8'd45,  8'd46,  8'd46,  8'd47,  8'd48,  8'd49,  8'd50,
      8'd51,  8'd52,  8'd53,  8'd53,  8'd54,  8'd55,  8'd56,  8'd57,
      8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd65,
      8'd66,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,  8'd72,  8'd73,
      8'd74,  8'd75,  8'd76,  8'd77,  8'd78,  8'd79,  8'd80,  8'd81,
      8'd82,  8'd83,  8'd84,  8'd86,  8'd87,  8'd88,  8'd89,  8'd90,
      8'd91,  8'd92,  8'd93,  8'd95,  8'd96,  8'd97,  8'd98,  8'd99,
      8'd100, 8'd102, 8'd103, 8'd104, 8'd105, 8'd107, 8'd108, 8'd109,
      8'd110, 8'd111, 8'd113, 8'd114, 8'd115, 8'd116, 8'd118, 8'd119,
      8'd120, 8'd122, 8'd123, 8'd124, 8'd126, 8'd127, 8'd128, 8'd129,
      8'd131, 8'd132, 8'd134, 8'd135, 8'd136, 8'd138, 8'd139, 8'd140,
      8'd142, 8'd143, 8'd145, 8'd146, 8'd147, 8'd149, 8'd150, 8'd152,
      8'd153, 8'd154, 8'd156, 8'd157, 8'd159, 8'd160, 8'd162, 8'd163,
      8'd165, 8'd166, 8'd168, 8'd169, 8'd171, 8'd172, 8'd174, 8'd175,
      8'd177, 8'd178, 8'd180, 8'd181, 8'd183, 8'd184, 8'd186, 8'd188,
      8'd189, 8'd191, 8'd192, 8'd194, 8'd195, 8'd197, 8'd199, 8'd200,
      8'd202, 8'd204, 8'd205, 8'd207, 8'd208, 8'd210, 8'd212, 8'd213,
      8'd215, 8'd217, 8'd218, 8'd220, 8'd222, 8'd224, 8'd225, 8'd227,
      8'd229, 8'd230, 8'd232, 8'd234, 8'd236, 8'd237, 8'd239, 8'd241,
      8'd243, 8'd244, 8'd246, 8'd248, 8'd250, 8'd251, 8'd253, 8'd255
  };

endpackage

@@ design/tilt_rotation_dimmer.sv @@
// Tilt and rotation lamp dimmer: sample register, update logic, result register.
//
// Usage:
//   Input channel (in_valid/in_ready): in_opcode 0 carries a signed tilt angle,
//   1 a signed rotation rate, in in_sample_value. Every transaction yields
//   exactly one result transaction on out_valid/out_ready.
//   A rate sample beyond the dead band moves the rotation position by
//   rate >>> 7, clamped to +/-255. An angle sample picks the lamp by sign,
//   derives a level from the magnitude with upright hysteresis and maps it
//   through the gamma table. Every result also carries the color wheel RGB
//   of the position and the position itself.
//   Path: a transaction passes the sample register, then the result register.
//   Throughput: one transaction per cycle unless the receiver stalls; the
//   position and upright flag are read and written in the same cycle, so
//   back-to-back samples see each other's updates.
//   Receiver stall: the result register holds; the sample register still
//   takes one more transaction, then in_ready drops until out_ready returns.
//   Reset (rst_n low, synchronous): both channels empty, position 0, not
//   upright, all configuration registers at their defaults.
//   Configuration: cfg_we writes cfg_wdata (low bits) to register cfg_index;
//   write only while no transaction is in flight.
`include "tilt_rotation_dimmer_assert.svh"

module tilt_rotation_dimmer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_opcode,
  input  logic signed [trd_pkg::SampleW-1:0] in_sample_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_lamp_select,
  output logic [7:0]                         out_drive_level,
  output logic                               out_shake_seen,
  output logic [7:0]                         out_wheel_red,
  output logic [7:0]                         out_wheel_green,
  output logic [7:0]                         out_wheel_blue,
  output logic signed [trd_pkg::PosW-1:0]    out_position_now,
  input  logic                               cfg_we,
  input  logic [trd_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [trd_pkg::CfgDataW-1:0]       cfg_wdata
);
  import trd_pkg::*;

  // Configuration registers
  logic [7:0]  rise_start_r, upright_low_r, upright_high_r, release_r, light_floor_r;
  logic [2:0]  level_shift_r;
  logic [14:0] rate_deadband_r, shake_limit_r;

  // Sample register
  logic                       s1_valid_r, s1_valid_nxt;
  logic                       s1_opcode_r;
  logic signed [SampleW-1:0]  s1_sample_r;

  // Block state
  logic signed [PosW-1:0]     pos_r, pos_nxt;
  logic                       upright_r, upright_nxt;

  // Result register
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_lamp_r, out_shake_r;
  logic [7:0]                 out_level_r, out_red_r, out_green_r, out_blue_r;
  logic signed [PosW-1:0]     out_pos_r;

  logic out_adv, in_accept, s1_move;

  // Datapath intermediates
  logic signed [16:0] s_ext, band_ext;
  logic signed [10:0] pos_sum;
  logic               neg, shake, in_rise, in_upright;
  logic [16:0]        mag, v;
  logic signed [17:0] lvl_sum;
  logic [7:0]         level_idx, level, lamp_level;
  logic [7:0]         w, wo, w3;
  logic [7:0]         red, green, blue;

  assign out_adv   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || out_adv;
  assign in_accept = in_valid && in_ready;
  assign s1_move   = s1_valid_r && out_adv;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (out_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_start_r    <= RISE_START_RST;
      upright_low_r   <= UPRIGHT_LOW_RST;
      upright_high_r  <= UPRIGHT_HIGH_RST;
      release_r       <= RELEASE_RST;
      light_floor_r   <= LIGHT_FLOOR_RST;
      level_shift_r   <= LEVEL_SHIFT_RST;
      rate_deadband_r <= RATE_DEADBAND_RST;
      shake_limit_r   <= SHAKE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_RISE_START:    rise_start_r    <= cfg_wdata[7:0];
        REG_UPRIGHT_LOW:   upright_low_r   <= cfg_wdata[7:0];
        REG_UPRIGHT_HIGH:  upright_high_r  <= cfg_wdata[7:0];
        REG_RELEASE:       release_r       <= cfg_wdata[7:0];
        REG_LIGHT_FLOOR:   light_floor_r   <= cfg_wdata[7:0];
        REG_LEVEL_SHIFT:   level_shift_r   <= cfg_wdata[2:0];
        REG_RATE_DEADBAND: rate_deadband_r <= cfg_wdata[14:0];
        REG_SHAKE_LIMIT:   shake_limit_r   <= cfg_wdata[14:0];
        default:           rise_start_r    <= rise_start_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      upright_r   <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      upright_r   <= upright_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_opcode_r <= in_opcode;
      s1_sample_r <= in_sample_value;
    end
    if (s1_move) begin
      out_lamp_r  <= neg && !s1_opcode_r;
      out_shake_r <= shake && !s1_opcode_r;
      out_level_r <= s1_opcode_r ? 8'd0 : lamp_level;
      out_red_r   <= red;
      out_green_r <= green;
      out_blue_r  <= blue;
      out_pos_r   <= pos_nxt;
    end
  end

  // Update logic: position, upright flag and level for the held sample
  always_comb begin
    s_ext    = {s1_sample_r[SampleW-1], s1_sample_r};
    band_ext = $signed({2'b00, rate_deadband_r});
    neg      = s1_sample_r[SampleW-1];
    mag      = neg ? 17'(-s_ext) : 17'(s_ext);
    v        = mag >> level_shift_r;
    lvl_sum  = $signed({1'b0, v}) + 18'(pos_r);
    shake    = neg && (mag > {2'b00, shake_limit_r});
    in_rise    = (mag >= {9'd0, rise_start_r}) && (mag < {9'd0, upright_low_r});
    in_upright = (mag >= {9'd0, upright_low_r}) && (mag <= {9'd0, upright_high_r});

    pos_nxt     = pos_r;
    upright_nxt = upright_r;
    level_idx   = 8'd0;
    pos_sum     = 11'(pos_r);

    if (s1_move) begin
      if (s1_opcode_r) begin
        // step is the sample shifted right by 7, sign kept
        if (s_ext > band_ext || s_ext < -band_ext) begin
          pos_sum = 11'(pos_r) + 11'($signed(s1_sample_r[SampleW-1:RateShift]));
        end
        if (pos_sum > POS_MAX) begin
          pos_nxt = PosW'(POS_MAX);
        end else if (pos_sum < POS_MIN) begin
          pos_nxt = PosW'(POS_MIN);
        end else begin
          pos_nxt = pos_sum[PosW-1:0];
        end
      end else if (!shake) begin
        if (in_rise) begin
          if (!upright_r || mag <= {9'd0, release_r}) begin
            upright_nxt = 1'b0;
            pos_nxt     = '0;
            level_idx   = v[7:0];
          end else begin
            level_idx   = lvl_sum[7:0];
          end
        end else if (in_upright) begin
          upright_nxt = 1'b1;
          if (lvl_sum >= 18'sd255) begin
            level_idx = 8'd255;
          end else if (lvl_sum <= $signed({10'd0, light_floor_r})) begin
            level_idx = light_floor_r;
          end else begin
            level_idx = lvl_sum[7:0];
          end
        end
      end
    end

    level      = GAMMA_ROM[level_idx];
    lamp_level = shake ? 8'd0 : level;

    // Color wheel from the low byte of the new position
    w     = 8'd255 - pos_nxt[7:0];
    red   = 8'd0;
    green = 8'd0;
    blue  = 8'd0;
    if (w < WHEEL_THIRD) begin
      wo   = w;
      w3   = 8'({wo, 1'b0} + {1'b0, wo});
      red  = 8'd255 - w3;
      blue = w3;
    end else if (w < WHEEL_TWOTHIRD) begin
      wo    = w - WHEEL_THIRD;
      w3    = 8'({wo, 1'b0} + {1'b0, wo});
      green = w3;
      blue  = 8'd255 - w3;
    end else begin
      wo    = w - WHEEL_TWOTHIRD;
      w3    = 8'({wo, 1'b0} + {1'b0, wo});
      red   = w3;
      green = 8'd255 - w3;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_lamp_select  = out_lamp_r;
  assign out_drive_level  = out_level_r;
  assign out_shake_seen   = out_shake_r;
  assign out_wheel_red    = out_red_r;
  assign out_wheel_green  = out_green_r;
  assign out_wheel_blue   = out_blue_r;
  assign out_position_now = out_pos_r;

  `TRD_ASSERT(a_pos_range, (pos_r <= 9'sd255) && (pos_r >= -9'sd255))
  `TRD_ASSERT(a_result_pos_current, out_valid_r |-> (out_pos_r == pos_r))
  `TRD_ASSERT(a_shake_dark, out_valid_r && out_shake_r |-> out_lamp_r && (out_level_r == 8'd0))
  `TRD_ASSERT(a_ready_when_empty, !out_valid_r |-> in_ready)
  `TRD_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid_r && !s1_valid_r && (pos_r == 9'sd0) && !upright_r)

endmodule
